// ===== hw/rtl/vyp_pkg.sv =====
// Shared types, widths and constants for the vector to yaw/pitch converter.
// Holds the arctangent table of the CORDIC cells; depends on nothing.
`default_nettype none

package vyp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int STAGE_W       = $clog2(CORDIC_STAGES);

	localparam int VEC_W   = 16;
	localparam int PITCH_W = 17;
	localparam int YAW_W   = 16;
	localparam int IN_W    = ((3 * VEC_W + 7) / 8) * 8;
	localparam int OUT_W   = ((PITCH_W + YAW_W + 7) / 8) * 8;

	localparam int SQ_W       = 2 * VEC_W - 1;
	localparam int SUM_W      = SQ_W + 1;
	localparam int ROOT_W     = 31;
	localparam int REM_W      = 32;
	localparam int SQRT_STEPS = ROOT_W;

	localparam int XW          = 35;
	localparam int AW          = 34;
	localparam int ACC_FRAC    = 23;
	localparam int ANG_FRAC    = 16;
	localparam int RND_W       = AW - ANG_FRAC;
	localparam int YAW_SHIFT   = 16;
	localparam int PITCH_SHIFT = 15;

	localparam logic signed [AW-1:0] HALF_ACC = AW'(180 * (1 << ACC_FRAC));
	localparam logic signed [AW-1:0] RND_HALF = AW'(1 << (ANG_FRAC - 1));

	localparam logic signed [RND_W-1:0] FULL_TURN   = RND_W'(46080);
	localparam logic signed [RND_W-1:0] QUARTER     = RND_W'(11520);
	localparam logic signed [RND_W-1:0] NEG_QUARTER = -QUARTER;
	localparam logic signed [RND_W-1:0] VERT_DOWN   = RND_W'(34560);

	typedef struct packed {
		logic                    vertical;
		logic                    z_pos;
		logic                    yaw_neg;
		logic signed [XW-1:0]    yx;
		logic signed [XW-1:0]    yy;
		logic signed [VEC_W-1:0] z;
	} carry_t;

	typedef struct packed {
		logic [SUM_W-1:0]  bits;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [AW-1:0] acc;
	} rot_t;

	typedef struct packed {
		logic vertical;
		logic z_pos;
		rot_t yaw;
		rot_t pitch;
	} cord_t;

	typedef struct packed {
		logic [YAW_W-1:0]          yaw;
		logic signed [PITCH_W-1:0] pitch;
	} res_t;

	// atan(2^-i) in units of 2^-23 degree
	function automatic logic signed [AW-1:0] atan_unit(input int i);
		logic signed [AW-1:0] v;
		case (i)
			0:       v = AW'(377487360);
			1:       v = AW'(222843801);
			2:       v = AW'(117744544);
			3:       v = AW'(59768969);
			4:       v = AW'(30000467);
			5:       v = AW'(15014858);
			6:       v = AW'(7509261);
			7:       v = AW'(3754860);
			8:       v = AW'(1877459);
			9:       v = AW'(938733);
			10:      v = AW'(469367);
			11:      v = AW'(234683);
			12:      v = AW'(117342);
			13:      v = AW'(58671);
			14:      v = AW'(29335);
			15:      v = AW'(14668);
			16:      v = AW'(7334);
			17:      v = AW'(3667);
			18:      v = AW'(1833);
			19:      v = AW'(917);
			20:      v = AW'(458);
			21:      v = AW'(229);
			22:      v = AW'(115);
			23:      v = AW'(57);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vyp_front.sv =====
// Input stages: squares of x and y, their sum, and the yaw pre-rotation.
// Depends on vyp_pkg.
`default_nettype none

module vyp_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               adv,
	input  wire                               in_vld,
	input  wire signed [vyp_pkg::VEC_W-1:0]   vec_x,
	input  wire signed [vyp_pkg::VEC_W-1:0]   vec_y,
	input  wire signed [vyp_pkg::VEC_W-1:0]   vec_z,
	output logic                              out_vld,
	output vyp_pkg::carry_t                   out_carry,
	output vyp_pkg::sqrt_t                    out_sq
);
	import vyp_pkg::*;

	logic signed [2*VEC_W-1:0] prod_x;
	logic signed [2*VEC_W-1:0] prod_y;
	logic signed [VEC_W:0]     ext_x;
	logic signed [VEC_W:0]     ext_y;
	logic signed [VEC_W:0]     ax;
	logic signed [VEC_W:0]     ay;
	carry_t                    carry_d;

	logic              vld_s1;
	logic [SQ_W-1:0]   xsq_s1;
	logic [SQ_W-1:0]   ysq_s1;
	carry_t            carry_s1;
	logic              vld_s2;
	carry_t            carry_s2;
	sqrt_t             sq_s2;

	assign prod_x = vec_x * vec_x;
	assign prod_y = vec_y * vec_y;

	always_comb begin
		ext_x = {vec_x[VEC_W-1], vec_x};
		ext_y = {vec_y[VEC_W-1], vec_y};
		ax = vec_x[VEC_W-1] ? -ext_x : ext_x;
		ay = vec_x[VEC_W-1] ? -ext_y : ext_y;
		carry_d.vertical = (vec_x == '0) && (vec_y == '0);
		carry_d.z_pos    = !vec_z[VEC_W-1] && (vec_z != '0);
		carry_d.yaw_neg  = vec_x[VEC_W-1];
		carry_d.yx       = XW'(ax) <<< YAW_SHIFT;
		carry_d.yy       = XW'(ay) <<< YAW_SHIFT;
		carry_d.z        = vec_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xsq_s1       <= prod_x[SQ_W-1:0];
			ysq_s1       <= prod_y[SQ_W-1:0];
			carry_s1     <= carry_d;
			carry_s2     <= carry_s1;
			sq_s2.bits   <= {1'b0, xsq_s1} + {1'b0, ysq_s1};
			sq_s2.rem    <= '0;
			sq_s2.root   <= '0;
		end
	end

	assign out_vld   = vld_s2;
	assign out_carry = carry_s2;
	assign out_sq    = sq_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/vyp_sqrt_cell.sv =====
// One digit cell of the square root chain: takes two bits of the radicand,
// yields one root bit, and hands the item on. Depends on vyp_pkg.
`default_nettype none

module vyp_sqrt_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    adv,
	input  wire                    in_vld,
	input  wire vyp_pkg::carry_t   in_carry,
	input  wire vyp_pkg::sqrt_t    in_sq,
	output logic                   out_vld,
	output vyp_pkg::carry_t        out_carry,
	output vyp_pkg::sqrt_t         out_sq
);
	import vyp_pkg::*;

	logic [REM_W+1:0] cur;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;
	sqrt_t            sq_d;

	logic   vld_q;
	carry_t carry_q;
	sqrt_t  sq_q;

	always_comb begin
		cur   = {in_sq.rem, in_sq.bits[SUM_W-1 -: 2]};
		trial = (REM_W + 2)'({in_sq.root, 2'b01});
		diff  = cur - trial;
		ge    = (cur >= trial);
		sq_d.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
		sq_d.root = {in_sq.root[ROOT_W-2:0], ge};
		sq_d.bits = {in_sq.bits[SUM_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_q <= in_carry;
			sq_q    <= sq_d;
		end
	end

	assign out_vld   = vld_q;
	assign out_carry = carry_q;
	assign out_sq    = sq_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vyp_cordic_cell.sv =====
// One CORDIC vectoring cell: a micro-rotation of the yaw and the pitch vector
// at the same shift, then a register. Depends on vyp_pkg.
`default_nettype none

module vyp_cordic_cell (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               adv,
	input  wire [vyp_pkg::STAGE_W-1:0]        shift,
	input  wire signed [vyp_pkg::AW-1:0]      angle,
	input  wire                               in_vld,
	input  wire vyp_pkg::cord_t               in_rot,
	output logic                              out_vld,
	output vyp_pkg::cord_t                    out_rot
);
	import vyp_pkg::*;

	function automatic rot_t rotate(input rot_t r, input logic [STAGE_W-1:0] sh,
		input logic signed [AW-1:0] ang);
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [AW-1:0] a;
		rot_t                 o;
		x  = r.x;
		y  = r.y;
		a  = r.acc;
		dx = y >>> sh;
		dy = x >>> sh;
		if (!y[XW-1] && (y != '0)) begin
			o.x   = x + dx;
			o.y   = y - dy;
			o.acc = a + ang;
		end else begin
			o.x   = x - dx;
			o.y   = y + dy;
			o.acc = a - ang;
		end
		return o;
	endfunction

	cord_t rot_d;
	logic  vld_q;
	cord_t rot_q;

	always_comb begin
		rot_d.vertical = in_rot.vertical;
		rot_d.z_pos    = in_rot.z_pos;
		rot_d.yaw      = rotate(in_rot.yaw, shift, angle);
		rot_d.pitch    = rotate(in_rot.pitch, shift, angle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rot_q <= rot_d;
		end
	end

	assign out_vld = vld_q;
	assign out_rot = rot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vyp_back.sv =====
// Output end: rounding, yaw wrap, pitch clamp, vertical override, and the
// output register with a skid entry that sets the pipeline advance. Depends on vyp_pkg.
`default_nettype none

module vyp_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_vld,
	input  wire vyp_pkg::cord_t    in_rot,
	output logic                   adv,
	input  wire                    out_ready,
	output logic                   out_valid,
	output vyp_pkg::res_t          out_res
);
	import vyp_pkg::*;

	logic signed [AW-1:0]    yaw_sum;
	logic signed [AW-1:0]    pitch_sum;
	logic signed [RND_W-1:0] yaw_w;
	logic signed [RND_W-1:0] pitch_c;
	res_t                    res;
	logic                    take;

	logic                    vld_s1;
	logic signed [RND_W-1:0] yaw_s1;
	logic signed [RND_W-1:0] pitch_s1;
	logic                    vert_s1;
	logic                    zpos_s1;

	logic out_vld_q;
	logic skid_vld_q;
	res_t out_q;
	res_t skid_q;

	assign yaw_sum   = in_rot.yaw.acc + RND_HALF;
	assign pitch_sum = in_rot.pitch.acc + RND_HALF;
	assign adv       = !skid_vld_q;
	assign take      = out_ready || !out_vld_q;

	always_comb begin
		yaw_w = yaw_s1;
		if (yaw_s1[RND_W-1]) begin
			yaw_w = yaw_s1 + FULL_TURN;
		end else if (yaw_s1 >= FULL_TURN) begin
			yaw_w = yaw_s1 - FULL_TURN;
		end
		pitch_c = pitch_s1;
		if (pitch_s1 > QUARTER) begin
			pitch_c = QUARTER;
		end else if (pitch_s1 < NEG_QUARTER) begin
			pitch_c = NEG_QUARTER;
		end
		if (vert_s1) begin
			res.yaw   = '0;
			res.pitch = zpos_s1 ? QUARTER[PITCH_W-1:0] : VERT_DOWN[PITCH_W-1:0];
		end else begin
			res.yaw   = yaw_w[YAW_W-1:0];
			res.pitch = pitch_c[PITCH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= in_vld;
			end
			if (take) begin
				out_vld_q  <= skid_vld_q || (adv && vld_s1);
				skid_vld_q <= 1'b0;
			end else if (adv && vld_s1) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_s1   <= yaw_sum[AW-1:ANG_FRAC];
			pitch_s1 <= pitch_sum[AW-1:ANG_FRAC];
			vert_s1  <= in_rot.vertical;
			zpos_s1  <= in_rot.z_pos;
		end
		if (take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (adv) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vector_to_yaw_pitch_top.sv =====
// Top level of the vector to yaw/pitch converter: front stages, square root
// cell chain, CORDIC cell chain and output end. Depends on vyp_pkg and all vyp_ modules.
//
//   channel  | signals            | payload (low bit first)
//   ---------+--------------------+---------------------------------------------
//   s_axis   | tvalid tready tdata| vec_x[15:0] vec_y[31:16] vec_z[47:32]
//   m_axis   | tvalid tready tdata| pitch[16:0] yaw[32:17], zero to bit 39
//
// One item per cycle while the output is not stalled; stages: 2 front stages, 31 square root cells
// (one root bit each), 16 CORDIC cells (one per stage), 1 rounding stage, output reg.
// Reset clears only valid bits; no clearing pass.
// A stalled output parks one result in a skid entry; the whole chain then holds
// and s_axis_tready drops until the output register drains it.
`default_nettype none

module vector_to_yaw_pitch_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire [vyp_pkg::IN_W-1:0]      s_axis_tdata,  // vec_x, vec_y, vec_z
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [vyp_pkg::OUT_W-1:0]    m_axis_tdata   // pitch, yaw
);
	import vyp_pkg::*;

	logic   adv;
	logic   sq_vld   [SQRT_STEPS+1];
	carry_t sq_carry [SQRT_STEPS+1];
	sqrt_t  sq_data  [SQRT_STEPS+1];
	logic   cr_vld   [CORDIC_STAGES+1];
	cord_t  cr_data  [CORDIC_STAGES+1];
	cord_t  cr_in;
	res_t   out_res;

	assign s_axis_tready = adv;

	vyp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (s_axis_tvalid),
		.vec_x     (s_axis_tdata[VEC_W-1:0]),
		.vec_y     (s_axis_tdata[2*VEC_W-1:VEC_W]),
		.vec_z     (s_axis_tdata[3*VEC_W-1:2*VEC_W]),
		.out_vld   (sq_vld[0]),
		.out_carry (sq_carry[0]),
		.out_sq    (sq_data[0])
	);

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		vyp_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_vld    (sq_vld[g]),
			.in_carry  (sq_carry[g]),
			.in_sq     (sq_data[g]),
			.out_vld   (sq_vld[g+1]),
			.out_carry (sq_carry[g+1]),
			.out_sq    (sq_data[g+1])
		);
	end

	always_comb begin
		cr_in.vertical  = sq_carry[SQRT_STEPS].vertical;
		cr_in.z_pos     = sq_carry[SQRT_STEPS].z_pos;
		cr_in.yaw.x     = sq_carry[SQRT_STEPS].yx;
		cr_in.yaw.y     = sq_carry[SQRT_STEPS].yy;
		cr_in.yaw.acc   = sq_carry[SQRT_STEPS].yaw_neg ? HALF_ACC : '0;
		cr_in.pitch.x   = XW'(sq_data[SQRT_STEPS].root);
		cr_in.pitch.y   = XW'(sq_carry[SQRT_STEPS].z) <<< PITCH_SHIFT;
		cr_in.pitch.acc = '0;
	end

	assign cr_vld[0]  = sq_vld[SQRT_STEPS];
	assign cr_data[0] = cr_in;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		vyp_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.shift   (STAGE_W'(g)),
			.angle   (atan_unit(g)),
			.in_vld  (cr_vld[g]),
			.in_rot  (cr_data[g]),
			.out_vld (cr_vld[g+1]),
			.out_rot (cr_data[g+1])
		);
	end

	vyp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (cr_vld[CORDIC_STAGES]),
		.in_rot    (cr_data[CORDIC_STAGES]),
		.adv       (adv),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {{(OUT_W - PITCH_W - YAW_W){1'b0}}, out_res};

endmodule

`default_nettype wire
